// ===== sv/lwc_pkg.sv =====
// shared types and constants for the learned interval wiper controller
`timescale 1ns / 1ps
`default_nettype none

package lwc_pkg;

    localparam int DEB_W   = 4;
    localparam int WORK_W  = 10;
    localparam int WAIT_W  = 12;
    localparam int LWORK_W = 11;
    localparam int LWAIT_W = 13;
    localparam int RUN_W   = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 12;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_DEBOUNCE_TICKS = 3'd0;
    localparam reg_idx_t REG_WORK_MIN       = 3'd1;
    localparam reg_idx_t REG_WORK_MAX       = 3'd2;
    localparam reg_idx_t REG_WAIT_MIN       = 3'd3;
    localparam reg_idx_t REG_WAIT_MAX       = 3'd4;

    localparam logic [DEB_W-1:0]  DEBOUNCE_TICKS_RST = 4'd3;
    localparam logic [WORK_W-1:0] WORK_MIN_RST       = 10'd15;
    localparam logic [WORK_W-1:0] WORK_MAX_RST       = 10'd300;
    localparam logic [WAIT_W-1:0] WAIT_MIN_RST       = 12'd60;
    localparam logic [WAIT_W-1:0] WAIT_MAX_RST       = 12'd1800;

    localparam logic [RUN_W-1:0]  RUN_STOP_NOW = 16'hFFFF;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [WORK_W-1:0] work_min;
        logic [WORK_W-1:0] work_max;
        logic [WAIT_W-1:0] wait_min;
        logic [WAIT_W-1:0] wait_max;
    } cfg_t;

    typedef struct packed {
        logic wiper_drive;
        logic indicator;
        logic learning;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/lwc_core.sv =====
// per-tick state update: debouncer, learn and use timers, wiper run control
`timescale 1ns / 1ps
`default_nettype none

module lwc_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic          switch_level,
    input  wire lwc_pkg::cfg_t cfg,
    output lwc_pkg::res_t      res
);

    logic                        sw_reg, sw_next;
    logic [lwc_pkg::DEB_W-1:0]   dbc_reg, dbc_next;
    logic                        use_reg, use_next;
    logic [lwc_pkg::LWORK_W-1:0] lwork_reg, lwork_next;
    logic [lwc_pkg::LWAIT_W-1:0] lwait_reg, lwait_next;
    logic [lwc_pkg::RUN_W-1:0]   run_reg, run_next;
    logic [lwc_pkg::LWAIT_W-1:0] ivl_reg, ivl_next;
    logic                        stop_reg, stop_next;
    logic                        motor_reg, motor_next;

    logic [lwc_pkg::LWORK_W-1:0] work_min_x, work_max_x;
    logic [lwc_pkg::LWAIT_W-1:0] wait_min_x, wait_max_x;
    logic [lwc_pkg::RUN_W-1:0]   limit;
    logic                        learned_bad;

    assign work_min_x = {1'b0, cfg.work_min};
    assign work_max_x = {1'b0, cfg.work_max};
    assign wait_min_x = {1'b0, cfg.wait_min};
    assign wait_max_x = {1'b0, cfg.wait_max};

    always_comb begin
        sw_next    = sw_reg;
        dbc_next   = dbc_reg;
        use_next   = use_reg;
        lwork_next = lwork_reg;
        lwait_next = lwait_reg;
        run_next   = run_reg;
        ivl_next   = ivl_reg;
        stop_next  = stop_reg;
        motor_next = motor_reg;
        learned_bad = (lwait_reg < wait_min_x) || (lwait_reg > wait_max_x) ||
                      (lwork_reg > work_max_x);

        // debounced switch handling
        if (dbc_reg == '0) begin
            if (switch_level != sw_reg) begin
                dbc_next = cfg.debounce_ticks;
            end
        end else begin
            if (dbc_reg == lwc_pkg::DEB_W'(1) && switch_level != sw_reg) begin
                sw_next = switch_level;
                if (!switch_level) begin
                    // press: restart learning or accept learned times
                    if (use_reg || learned_bad) begin
                        use_next   = 1'b0;
                        lwait_next = '0;
                        lwork_next = '0;
                        stop_next  = 1'b0;
                        motor_next = 1'b1;
                        run_next   = '0;
                    end else begin
                        use_next  = 1'b1;
                        stop_next = 1'b0;
                        ivl_next  = '0;
                    end
                end else begin
                    if (use_reg) begin
                        if (run_reg >= {6'd0, cfg.work_min}) begin
                            run_next = lwc_pkg::RUN_STOP_NOW;
                        end
                    end else begin
                        if (lwork_reg < work_min_x) begin
                            lwork_next = work_min_x;
                        end
                    end
                    stop_next = 1'b1;
                end
            end
            dbc_next = dbc_reg - lwc_pkg::DEB_W'(1);
        end

        // timers
        if (!use_next) begin
            if (lwait_next <= wait_max_x) begin
                lwait_next = lwait_next + lwc_pkg::LWAIT_W'(1);
            end
            if (!sw_next && lwork_next <= work_max_x) begin
                lwork_next = lwork_next + lwc_pkg::LWORK_W'(1);
            end
        end else if (!sw_next) begin
            if (ivl_next == '0) begin
                motor_next = 1'b1;
                run_next   = '0;
                stop_next  = 1'b1;
                ivl_next   = lwait_next;
            end
            // wraps when the learned wait is zero
            ivl_next = ivl_next - lwc_pkg::LWAIT_W'(1);
        end

        // wiper run
        limit = use_next ? {5'd0, lwork_next} : {6'd0, cfg.work_min};
        if (run_next < limit) begin
            run_next = run_next + lwc_pkg::RUN_W'(1);
        end else if (stop_next) begin
            motor_next = 1'b0;
            stop_next  = 1'b0;
        end
    end

    always_comb begin
        res.wiper_drive = motor_next;
        res.indicator   = !sw_next && use_next;
        res.learning    = !use_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg    <= 1'b1;
            dbc_reg   <= '0;
            use_reg   <= 1'b1;
            lwork_reg <= '0;
            lwait_reg <= '0;
            run_reg   <= '0;
            ivl_reg   <= '0;
            stop_reg  <= 1'b0;
            motor_reg <= 1'b0;
        end else if (step_en) begin
            sw_reg    <= sw_next;
            dbc_reg   <= dbc_next;
            use_reg   <= use_next;
            lwork_reg <= lwork_next;
            lwait_reg <= lwait_next;
            run_reg   <= run_next;
            ivl_reg   <= ivl_next;
            stop_reg  <= stop_next;
            motor_reg <= motor_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_dbc_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && dbc_reg != '0 |=> dbc_reg == $past(dbc_reg) - lwc_pkg::DEB_W'(1))
        else $error("debounce count did not step down");

    a_no_change_without_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && dbc_reg == '0 && switch_level == sw_reg |=> $stable(sw_reg))
        else $error("switch state changed without a level difference");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(motor_reg) && $stable(use_reg) && $stable(run_reg))
        else $error("state moved without a request");
`endif

endmodule

`default_nettype wire

// ===== sv/lwc_outbuf.sv =====
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps
`default_nettype none

module lwc_outbuf (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire lwc_pkg::res_t push_data,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lwc_pkg::res_t      out_data
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    lwc_pkg::res_t out_reg, out_next;
    lwc_pkg::res_t skid_reg, skid_next;
    logic          pop;

    assign pop       = out_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end else if (push) begin
            // output stalled, park the request
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !out_valid_reg |=> out_valid_reg && out_reg == $past(push_data))
        else $error("request lost on empty buffer");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("request pushed into full buffer");
`endif

endmodule

`default_nettype wire

// ===== sv/learned_interval_wiper_controller.sv =====
// top level: configuration registers, tick core and result buffer
`timescale 1ns / 1ps
`default_nettype none

// Learned interval wiper controller. Each input request is one timer tick with
// the raw switch level (0 pressed) and yields exactly one result: wiper drive,
// indicator and learn flag. The state update logic handles a tick combinationally
// and its result is registered in a two-entry output buffer, so one request is
// taken every cycle; input ready drops only when both buffer entries are full.
// A result waits in the skid register while the output stalls. Configuration
// writes (index 0..4: debounce_ticks, work_min, work_max, wait_min, wait_max,
// data in the low bits) are always ready; other indexes are ignored.

module learned_interval_wiper_controller (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_switch_level,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_wiper_drive,
    output logic                           m_indicator,
    output logic                           m_learning,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire lwc_pkg::reg_idx_t         cfg_index,
    input  wire logic [lwc_pkg::DATA_W-1:0] cfg_data
);

    lwc_pkg::cfg_t cfg_reg, cfg_next;
    lwc_pkg::res_t core_res;
    lwc_pkg::res_t out_res;
    logic          buf_full;
    logic          push;

    assign cfg_ready = 1'b1;
    assign s_ready   = !buf_full;
    assign push      = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lwc_pkg::REG_DEBOUNCE_TICKS:
                    cfg_next.debounce_ticks = cfg_data[lwc_pkg::DEB_W-1:0];
                lwc_pkg::REG_WORK_MIN: cfg_next.work_min = cfg_data[lwc_pkg::WORK_W-1:0];
                lwc_pkg::REG_WORK_MAX: cfg_next.work_max = cfg_data[lwc_pkg::WORK_W-1:0];
                lwc_pkg::REG_WAIT_MIN: cfg_next.wait_min = cfg_data[lwc_pkg::WAIT_W-1:0];
                lwc_pkg::REG_WAIT_MAX: cfg_next.wait_max = cfg_data[lwc_pkg::WAIT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= lwc_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.work_min       <= lwc_pkg::WORK_MIN_RST;
            cfg_reg.work_max       <= lwc_pkg::WORK_MAX_RST;
            cfg_reg.wait_min       <= lwc_pkg::WAIT_MIN_RST;
            cfg_reg.wait_max       <= lwc_pkg::WAIT_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lwc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (push),
        .switch_level (s_switch_level),
        .cfg          (cfg_reg),
        .res          (core_res)
    );

    lwc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (core_res),
        .full      (buf_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_wiper_drive = out_res.wiper_drive;
    assign m_indicator   = out_res.indicator;
    assign m_learning    = out_res.learning;

endmodule

`default_nettype wire

// ===== dv/lwc_checker.sv =====
// checker for the wiper controller: predicts each tick's outputs and compares them
`timescale 1ns / 1ps

module lwc_checker import lwc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic              s_switch_level,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic              m_wiper_drive,
    input  wire logic              m_indicator,
    input  wire logic              m_learning,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire reg_idx_t          cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    cfg_t               cfg;
    logic               sw_level;
    logic [DEB_W-1:0]   deb_cnt;
    logic               use_mode;
    logic [LWORK_W-1:0] lwork;
    logic [LWAIT_W-1:0] lwait;
    logic [RUN_W-1:0]   run_t;
    logic [LWAIT_W-1:0] ivl_t;
    logic               stop_pend;
    logic               motor;

    res_t pending_outputs[$];

    // one tick: switch debounce, then timers, then the wiper run
    task automatic step_wiper(input logic lvl, output res_t r);
        logic [LWORK_W-1:0] limit;
        if (deb_cnt == 0) begin
            if (lvl != sw_level)
                deb_cnt = cfg.debounce_ticks;
        end else begin
            if (deb_cnt == 1 && lvl != sw_level) begin
                sw_level = lvl;
                if (lvl == 1'b0) begin
                    if (use_mode || lwait < cfg.wait_min || lwait > cfg.wait_max ||
                        lwork > cfg.work_max) begin
                        // start learning over
                        use_mode  = 1'b0;
                        lwait     = '0;
                        lwork     = '0;
                        stop_pend = 1'b0;
                        motor     = 1'b1;
                        run_t     = '0;
                    end else begin
                        use_mode  = 1'b1;
                        stop_pend = 1'b0;
                        ivl_t     = '0;
                    end
                end else begin
                    if (use_mode) begin
                        if (run_t >= cfg.work_min)
                            run_t = RUN_STOP_NOW;
                    end else if (lwork < cfg.work_min) begin
                        lwork = LWORK_W'(cfg.work_min);
                    end
                    stop_pend = 1'b1;
                end
            end
            deb_cnt = deb_cnt - 1'b1;
        end

        if (!use_mode) begin
            if (lwait <= cfg.wait_max)
                lwait = lwait + 1'b1;
            if (sw_level == 1'b0 && lwork <= cfg.work_max)
                lwork = lwork + 1'b1;
        end else if (sw_level == 1'b0) begin
            if (ivl_t == 0) begin
                motor     = 1'b1;
                run_t     = '0;
                stop_pend = 1'b1;
                ivl_t     = lwait;
            end
            // wraps when the learned wait is zero
            ivl_t = ivl_t - 1'b1;
        end

        limit = use_mode ? lwork : LWORK_W'(cfg.work_min);
        if (run_t < limit) begin
            run_t = run_t + 1'b1;
        end else if (stop_pend) begin
            motor     = 1'b0;
            stop_pend = 1'b0;
        end

        r.wiper_drive = motor;
        r.indicator   = !sw_level && use_mode;
        r.learning    = !use_mode;
    endtask

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        res_t nxt;
        if (!aresetn) begin
            cfg.debounce_ticks = DEBOUNCE_TICKS_RST;
            cfg.work_min       = WORK_MIN_RST;
            cfg.work_max       = WORK_MAX_RST;
            cfg.wait_min       = WAIT_MIN_RST;
            cfg.wait_max       = WAIT_MAX_RST;
            sw_level  = 1'b1;
            deb_cnt   = '0;
            use_mode  = 1'b1;
            lwork     = '0;
            lwait     = '0;
            run_t     = '0;
            ivl_t     = '0;
            stop_pend = 1'b0;
            motor     = 1'b0;
            pending_outputs.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS: cfg.debounce_ticks = cfg_data[DEB_W-1:0];
                    REG_WORK_MIN:       cfg.work_min       = cfg_data[WORK_W-1:0];
                    REG_WORK_MAX:       cfg.work_max       = cfg_data[WORK_W-1:0];
                    REG_WAIT_MIN:       cfg.wait_min       = cfg_data[WAIT_W-1:0];
                    REG_WAIT_MAX:       cfg.wait_max       = cfg_data[WAIT_W-1:0];
                    default: ;
                endcase
            end

            // results are registered after their request, so pop before push
            if (m_valid && m_ready) begin
                got.wiper_drive = m_wiper_drive;
                got.indicator   = m_indicator;
                got.learning    = m_learning;
                if (pending_outputs.size() == 0) begin
                    $error("result with no request waiting: %s %0d %s %0d %s %0d",
                           "wiper_drive", got.wiper_drive, "indicator", got.indicator,
                           "learning", got.learning);
                    fail_count++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (got.wiper_drive !== want.wiper_drive) begin
                        $error("wiper_drive: expected %0d, actual %0d",
                               want.wiper_drive, got.wiper_drive);
                        fail_count++;
                    end
                    if (got.indicator !== want.indicator) begin
                        $error("indicator: expected %0d, actual %0d",
                               want.indicator, got.indicator);
                        fail_count++;
                    end
                    if (got.learning !== want.learning) begin
                        $error("learning: expected %0d, actual %0d",
                               want.learning, got.learning);
                        fail_count++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                step_wiper(s_switch_level, nxt);
                pending_outputs.push_back(nxt);
            end
            outstanding <= pending_outputs.size();
        end
    end

endmodule

// ===== dv/tb_learned_interval_wiper_controller.sv =====
// testbench top for the wiper controller: clock, reset, tick stimulus and verdict
`timescale 1ns / 1ps

module tb_learned_interval_wiper_controller;
    import lwc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_switch_level = 1'b1;
    logic              m_ready        = 1'b0;
    logic              cfg_valid      = 1'b0;
    reg_idx_t          cfg_index      = REG_DEBOUNCE_TICKS;
    logic [DATA_W-1:0] cfg_data       = '0;

    wire s_ready;
    wire m_valid;
    wire m_wiper_drive;
    wire m_indicator;
    wire m_learning;
    wire cfg_ready;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int calm_left   = 0;
    int cur_deb     = DEBOUNCE_TICKS_RST;
    bit cur_level   = 1'b1;

    learned_interval_wiper_controller uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_switch_level (s_switch_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_wiper_drive  (m_wiper_drive),
        .m_indicator    (m_indicator),
        .m_learning     (m_learning),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    lwc_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_switch_level (s_switch_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_wiper_drive  (m_wiper_drive),
        .m_indicator    (m_indicator),
        .m_learning     (m_learning),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_learned_interval_wiper_controller: FAIL");
            $finish;
        end
    end

    // receiver: stall runs, calm stretches and random single cycles
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left <= calm_left - 1;
            m_ready   <= 1'b1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_left <= $urandom_range(1, 8);
                    m_ready    <= 1'b0;
                end
                1: begin
                    calm_left <= $urandom_range(10, 60);
                    m_ready   <= 1'b1;
                end
                default: m_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // n ticks at one switch level, sent in bursts with random gaps
    task automatic send_run(input bit lvl, input int n);
        int gap;
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                repeat (gap) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            s_valid        <= 1'b1;
            s_switch_level <= lvl;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            burst_left--;
        end
        cur_level = lvl;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // upper data bits above each register's width are random and must be dropped
    task automatic apply_setting(input int deb, input int wmin, input int wmax,
                                 input int wtmin, input int wtmax);
        wait_idle();
        write_reg(REG_DEBOUNCE_TICKS, (DATA_W'($urandom) << DEB_W) | DATA_W'(deb));
        write_reg(REG_WORK_MIN, (DATA_W'($urandom) << WORK_W) | DATA_W'(wmin));
        write_reg(REG_WORK_MAX, (DATA_W'($urandom) << WORK_W) | DATA_W'(wmax));
        write_reg(REG_WAIT_MIN, DATA_W'(wtmin));
        write_reg(REG_WAIT_MAX, DATA_W'(wtmax));
        write_reg(reg_idx_t'($urandom_range(int'(REG_WAIT_MAX) + 1, (1 << IDX_W) - 1)),
                  DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_deb = deb;
    endtask

    // alternating press and release holds, with glitches and a little noise
    task automatic run_phase(input int budget, input int scale);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0: begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        send_run(1'($urandom_range(0, 1)), 1);
                end
                1: begin
                    // shorter than the debounce count (one tick when that is 1 or less), should be filtered
                    len = $urandom_range(1, (cur_deb > 1) ? cur_deb - 1 : 1);
                    send_run(~cur_level, len);
                end
                default: begin
                    len = cur_deb + 1 + ($urandom_range(0, 1) ?
                          $urandom_range(0, scale / 4) : $urandom_range(0, scale));
                    send_run(~cur_level, len);
                end
            endcase
            sent += len;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: a filtered glitch, then a real press that starts learning
        send_run(1'b1, 2);
        send_run(1'b0, 1);
        send_run(1'b1, 3);
        send_run(1'b0, 5);
        apply_setting(1, 2, 4, 3, 30);
        send_run(1'b0, 2);
        send_run(1'b1, 3);
        send_run(1'b0, 9);
        send_run(1'b1, 2);

        apply_setting(2, 3, 12, 6, 30);
        run_phase(100, 40);
        apply_setting(0, 3, 12, 6, 30);
        run_phase(80, 20);
        apply_setting(15, 0, (1 << WORK_W) - 1, 0, (1 << WAIT_W) - 1);
        run_phase(120, 60);
        apply_setting(1, (1 << WORK_W) - 1, 0, (1 << WAIT_W) - 1, 0);
        run_phase(100, 30);
        apply_setting(DEBOUNCE_TICKS_RST, WORK_MIN_RST, WORK_MAX_RST,
                      WAIT_MIN_RST, WAIT_MAX_RST);
        run_phase(160, 120);
        repeat (3) begin
            apply_setting($urandom_range(1, 4), $urandom_range(0, 8), $urandom_range(0, 20),
                          $urandom_range(0, 10), $urandom_range(5, 40));
            run_phase(80, 40);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_learned_interval_wiper_controller: PASS");
        else
            $display("tb_learned_interval_wiper_controller: FAIL");
        $finish;
    end

endmodule
